// ===== hw/rtl/chacha_pkg.sv =====
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared types, constants and block setup for the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package chacha_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR   = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       msg_start;
    logic       msg_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
  } out_item_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_low;
    logic [31:0]      nonce_high;
    logic [31:0]      initial_counter;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        msg_end;
    logic        build;
    logic [5:0]  pos;
    logic [31:0] ctr;
  } entry_t;

  typedef logic [15:0][31:0] block_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_FINAL,
    BK_EMIT
  } back_state_t;

  function automatic block_t chacha_init(cfg_t cfg, logic [31:0] ctr);
    block_t b;
    b[0]  = SIGMA_0;
    b[1]  = SIGMA_1;
    b[2]  = SIGMA_2;
    b[3]  = SIGMA_3;
    b[4]  = cfg.key[0][31:0];
    b[5]  = cfg.key[0][63:32];
    b[6]  = cfg.key[1][31:0];
    b[7]  = cfg.key[1][63:32];
    b[8]  = cfg.key[2][31:0];
    b[9]  = cfg.key[2][63:32];
    b[10] = cfg.key[3][31:0];
    b[11] = cfg.key[3][63:32];
    b[12] = ctr;
    b[13] = cfg.nonce_low[31:0];
    b[14] = cfg.nonce_low[63:32];
    b[15] = cfg.nonce_high;
    return b;
  endfunction

endpackage

// ===== hw/rtl/chacha20_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 byte-stream cipher with queue-style input and result ports.
// ----------------------------------------------------------------------------
// Bytes that use an existing keystream block pass in one cycle each while
// the result port is popped. A byte that opens a block (first byte after
// reset, message start or 64 bytes used) waits while the round engine loads
// the block, runs the shared add-xor-rotate unit, adds the feed-forward and
// emits the byte. A four-entry queue lets input bytes keep arriving while a
// block is computed. Key, nonce and counter must be written by the user only
// while no transaction is in flight; the module itself has no check for this.
module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  chacha_pkg::in_item_t                in_data,
  output logic                                empty,
  input  logic                                pop,
  output chacha_pkg::out_item_t               out_data,
  input  logic                                cfg_we,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  chacha_pkg::cfg_t   cfg;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  chacha_pkg::entry_t q_wdata;
  chacha_pkg::entry_t q_head;
  logic               building;

  assign full = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        chacha_pkg::CFG_KEY_0:      cfg.key[0]          <= cfg_wdata;
        chacha_pkg::CFG_KEY_1:      cfg.key[1]          <= cfg_wdata;
        chacha_pkg::CFG_KEY_2:      cfg.key[2]          <= cfg_wdata;
        chacha_pkg::CFG_KEY_3:      cfg.key[3]          <= cfg_wdata;
        chacha_pkg::CFG_NONCE_LOW:  cfg.nonce_low       <= cfg_wdata;
        chacha_pkg::CFG_NONCE_HIGH: cfg.nonce_high      <= cfg_wdata[31:0];
        chacha_pkg::CFG_INIT_CTR:   cfg.initial_counter <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  chacha_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_data (in_data),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  chacha_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr_en (q_push),
    .wdata (q_wdata),
    .rd_en (q_pop),
    .rdata (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  chacha_back #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data),
    .building (building)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_no_result_building: assert property (@(posedge clk) disable iff (rst)
    building && empty |=> empty)
    else $error("result produced while a block is being built");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> empty && !building)
    else $error("back end not idle after reset");
`endif

endmodule

// ===== hw/rtl/chacha_fifo.sv =====
// ----------------------------------------------------------------------------
// chacha_fifo
// Short queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module chacha_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  chacha_pkg::entry_t wdata,
  input  logic               rd_en,
  output chacha_pkg::entry_t rdata,
  output logic               full,
  output logic               empty
);

  chacha_pkg::entry_t                 mem [chacha_pkg::QUEUE_DEPTH];
  logic [chacha_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [chacha_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [chacha_pkg::QUEUE_AW:0]      count;

  assign full  = count == (chacha_pkg::QUEUE_AW+1)'(chacha_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/chacha_front.sv =====
// ----------------------------------------------------------------------------
// chacha_front
// Accepts input bytes, tracks keystream position and block counter, and
// marks the bytes that need a fresh keystream block.
// ----------------------------------------------------------------------------
module chacha_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  chacha_pkg::in_item_t in_data,
  input  chacha_pkg::cfg_t     cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output chacha_pkg::entry_t   q_wdata
);

  logic [5:0]  pos;
  logic [31:0] blk_ctr;
  logic        stream_valid;
  logic        restart;

  always_comb begin
    restart           = in_data.msg_start || !stream_valid;
    q_wdata.data_byte = in_data.data_byte;
    q_wdata.msg_end   = in_data.msg_end;
    q_wdata.pos       = restart ? 6'd0 : pos;
    q_wdata.build     = restart || (pos == 6'd0);
    q_wdata.ctr       = restart ? cfg.initial_counter : blk_ctr;
    q_push            = push && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      blk_ctr      <= '0;
      stream_valid <= 1'b0;
    end else if (q_push) begin
      pos          <= q_wdata.pos + 6'd1;
      stream_valid <= 1'b1;
      if (q_wdata.build) begin
        blk_ctr <= q_wdata.ctr + 32'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/chacha_back.sv =====
// ----------------------------------------------------------------------------
// chacha_back
// Round engine and output stage: builds keystream blocks on demand, one
// add-xor-rotate step of four quarter rounds per cycle, and XORs bytes.
// ----------------------------------------------------------------------------
module chacha_back #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  chacha_pkg::cfg_t      cfg,
  input  logic                  q_empty,
  input  chacha_pkg::entry_t    q_head,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output chacha_pkg::out_item_t out_data,
  output logic                  building
);

  localparam int STEPS  = 8 * DOUBLE_ROUNDS;
  localparam int STEP_W = $clog2(STEPS);

  chacha_pkg::back_state_t state, state_next;
  chacha_pkg::block_t      w;
  logic [STEP_W-1:0]       step_cnt;
  logic [31:0]             ctr;
  chacha_pkg::entry_t      cur;
  logic                    out_valid;
  chacha_pkg::out_item_t   out_q;

  logic                    out_free;
  logic                    load;
  logic                    emit_head;
  logic                    emit_cur;
  chacha_pkg::entry_t      src;
  logic [31:0]             ks_word;
  logic [7:0]              ks_byte;
  chacha_pkg::block_t      init_blk;
  chacha_pkg::block_t      step_blk;

  function automatic chacha_pkg::block_t qr_step(chacha_pkg::block_t v, logic diag,
                                                  logic [1:0] step);
    chacha_pkg::block_t r;
    logic [1:0]  jj;
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] a, b, c, d, s, x;
    r = v;
    for (int j = 0; j < 4; j++) begin
      jj = 2'(j);
      ia = {2'd0, jj};
      ib = {2'd1, jj + {1'b0, diag}};
      ic = {2'd2, jj + {diag, 1'b0}};
      id = {2'd3, jj + {diag, diag}};
      a  = v[ia];
      b  = v[ib];
      c  = v[ic];
      d  = v[id];
      case (step)
        2'd0: begin
          s = a + b;  x = d ^ s;
          r[ia] = s;  r[id] = {x[15:0], x[31:16]};
        end
        2'd1: begin
          s = c + d;  x = b ^ s;
          r[ic] = s;  r[ib] = {x[19:0], x[31:20]};
        end
        2'd2: begin
          s = a + b;  x = d ^ s;
          r[ia] = s;  r[id] = {x[23:0], x[31:24]};
        end
        default: begin
          s = c + d;  x = b ^ s;
          r[ic] = s;  r[ib] = {x[24:0], x[31:25]};
        end
      endcase
    end
    return r;
  endfunction

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign out_data = out_q;
  assign building = (state == chacha_pkg::BK_ROUND) || (state == chacha_pkg::BK_FINAL);

  always_comb begin
    init_blk = chacha_pkg::chacha_init(cfg, load ? q_head.ctr : ctr);
    step_blk = qr_step(w, step_cnt[2], step_cnt[1:0]);
    src      = emit_cur ? cur : q_head;
    ks_word  = w[src.pos[5:2]];
    ks_byte  = 8'(ks_word >> {src.pos[1:0], 3'b000});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chacha_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load       = 1'b0;
    emit_head  = 1'b0;
    emit_cur   = 1'b0;
    unique case (state)
      chacha_pkg::BK_IDLE: begin
        if (!q_empty && q_head.build) begin
          q_pop      = 1'b1;
          load       = 1'b1;
          state_next = chacha_pkg::BK_ROUND;
        end else if (!q_empty && out_free) begin
          q_pop     = 1'b1;
          emit_head = 1'b1;
        end
      end
      chacha_pkg::BK_ROUND: begin
        if (step_cnt == STEP_W'(STEPS - 1)) begin
          state_next = chacha_pkg::BK_FINAL;
        end
      end
      chacha_pkg::BK_FINAL: begin
        state_next = chacha_pkg::BK_EMIT;
      end
      chacha_pkg::BK_EMIT: begin
        if (out_free) begin
          emit_cur   = 1'b1;
          state_next = chacha_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = chacha_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      w   <= init_blk;
      ctr <= q_head.ctr;
      cur <= q_head;
    end else if (state == chacha_pkg::BK_ROUND) begin
      w <= step_blk;
    end else if (state == chacha_pkg::BK_FINAL) begin
      for (int i = 0; i < 16; i++) begin
        w[i] <= w[i] + init_blk[i];
      end
    end
    if (emit_head || emit_cur) begin
      out_q.out_byte <= src.data_byte ^ ks_byte;
      out_q.out_end  <= src.msg_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step_cnt <= '0;
      end else if (state == chacha_pkg::BK_ROUND) begin
        step_cnt <= step_cnt + 1'b1;
      end
      if (emit_head || emit_cur) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
